@@ rtl/ufct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufct_pkg: shared types and constants for the union-find cluster tracker
// Field widths, reset values and the sequencer state encoding.
// ---------------------------------------------------------------------------
package ufct_pkg;

    // Payload field widths
    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;

    // Reset value of the node count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Default forest depth
    localparam int MAX_NODES_DEF = 1024;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_PATH_RD,
        ST_PATH_CHK,
        ST_LINK_KEEP,
        ST_LINK_JOIN,
        ST_DONE
    } ufct_state_t;

endpackage

`default_nettype wire

@@ rtl/ufct_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufct_if: handshake channels of the union-find cluster tracker
// Edge input, statistics result and node count write channel.
// ---------------------------------------------------------------------------

// Edge item: two endpoints
interface ufct_edge_if import ufct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output node_a, output node_b, input ready);
    modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

// Result item: cluster statistics after one edge
interface ufct_stats_if import ufct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] cluster_count;
    logic [COUNT_W-1:0] largest_size;
    logic               bad_node;

    modport source (output valid, output cluster_count, output largest_size,
                    output bad_node, input ready);
    modport sink   (input valid, input cluster_count, input largest_size,
                    input bad_node, output ready);
endinterface

// Node count register write
interface ufct_cfg_if import ufct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

`default_nettype wire

@@ rtl/union_find_cluster_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An edge with an out-of-range endpoint skips the walk; an edge that merges
// two clusters ends with the link writes, LINK_KEEP and then LINK_JOIN.
// Each parent hop is a read and a check of the forest RAM, and
// each compressed node another read and write, so the RAM accesses set the rate.
// One edge at a time; a finished result waits in an output register.
// Reset and every node_count write start a RAM clearing pass over all MAX_NODES entries.
// ---------------------------------------------------------------------------
// union_find_cluster_tracker: disjoint-set engine with union by size
// Walks both parent chains, compresses them, joins the smaller set under
// the larger one and reports cluster count and largest cluster size.
// ---------------------------------------------------------------------------
module union_find_cluster_tracker
    import ufct_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    ufct_cfg_if.sink     cfg,
    ufct_edge_if.sink    edges,
    ufct_stats_if.source stats
);

    // Index, size and entry widths
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW = IW + 1;
    localparam int EW = SW + 1;
    localparam int CW = (SW > COUNT_W) ? SW : COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_NODES);

    // Forest RAM: {root flag, size for a root / parent index otherwise}
    logic [EW-1:0] mem [MAX_NODES];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    ufct_state_t state_reg, state_next;

    logic [COUNT_W-1:0] node_count_reg;
    logic [IW-1:0]      node_a_reg, node_b_reg;
    logic [IW-1:0]      walk_reg;
    logic [IW-1:0]      root_a_reg, root_b_reg;
    logic [SW-1:0]      size_a_reg, size_b_reg;
    logic               side_reg;
    logic               bad_reg;
    logic [IW-1:0]      clr_idx_reg;
    logic [SW-1:0]      merge_reg;
    logic [SW-1:0]      largest_reg;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_largest_reg;
    logic               out_bad_reg;

    logic          cfg_write;
    logic          in_accept;
    logic          out_load;
    logic [CW-1:0] cnt;
    logic          in_bad;
    logic          rd_root;
    logic [IW-1:0] rd_parent;
    logic [SW-1:0] rd_size;
    logic [IW-1:0] root_cur;
    logic          keep_b;
    logic [IW-1:0] keep_idx, join_idx;
    logic [SW-1:0] sum_size;
    logic [CW-1:0] count_diff;

    // Handshakes; a register write waits for an idle or clearing block and wins over an edge
    assign cfg.ready   = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign cfg_write   = cfg.valid && ((state_reg == ST_IDLE) || (state_reg == ST_CLEAR));
    assign edges.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign in_accept   = edges.valid && (state_reg == ST_IDLE) && !cfg.valid;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || stats.ready);

    // Active node count, saturated at the forest depth
    assign cnt    = (CW'(node_count_reg) > MAX_CNT) ? MAX_CNT : CW'(node_count_reg);
    assign in_bad = (CW'(edges.node_a) >= cnt) || (CW'(edges.node_b) >= cnt);

    // Fields of the entry just read
    assign rd_root   = rd_data_reg[EW-1];
    assign rd_parent = rd_data_reg[IW-1:0];
    assign rd_size   = rd_data_reg[SW-1:0];
    assign root_cur  = side_reg ? root_b_reg : root_a_reg;

    // Union by size; on a tie node_a's root stays
    assign keep_b     = (size_a_reg < size_b_reg);
    assign keep_idx   = keep_b ? root_b_reg : root_a_reg;
    assign join_idx   = keep_b ? root_a_reg : root_b_reg;
    assign sum_size   = size_a_reg + size_b_reg;
    assign count_diff = cnt - CW'(merge_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = in_bad ? ST_DONE : ST_FIND_RD;
            end
            ST_FIND_RD:
                state_next = ST_FIND_CHK;
            ST_FIND_CHK:
                state_next = rd_root ? ST_PATH_RD : ST_FIND_RD;
            ST_PATH_RD:
            begin
                if (walk_reg != root_cur)
                    state_next = ST_PATH_CHK;
                else if (!side_reg)
                    state_next = ST_FIND_RD;
                else if (root_a_reg != root_b_reg)
                    state_next = ST_LINK_KEEP;
                else
                    state_next = ST_DONE;
            end
            ST_PATH_CHK:
                state_next = ST_PATH_RD;
            ST_LINK_KEEP:
                state_next = ST_LINK_JOIN;
            ST_LINK_JOIN:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
        // A register write restarts the clearing pass
        if (cfg_write)
            state_next = ST_CLEAR;
    end

    // RAM write controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_reg;
        mem_wdata = {1'b0, {(SW-IW){1'b0}}, root_cur};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = {1'b1, SW'(1)};
            end
            ST_PATH_CHK:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                mem_wdata = {1'b0, {(SW-IW){1'b0}}, root_cur};
            end
            ST_LINK_KEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = keep_idx;
                mem_wdata = {1'b1, sum_size};
            end
            ST_LINK_JOIN:
            begin
                mem_we    = 1'b1;
                mem_waddr = join_idx;
                mem_wdata = {1'b0, {(SW-IW){1'b0}}, keep_idx};
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    // Forest RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[walk_reg];
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Control counters and cluster statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_RESET;
            clr_idx_reg    <= '0;
            merge_reg      <= '0;
            largest_reg    <= SW'(1);
        end
        else if (cfg_write)
        begin
            node_count_reg <= cfg.node_count;
            clr_idx_reg    <= '0;
            merge_reg      <= '0;
            largest_reg    <= SW'(1);
        end
        else
        begin
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (state_reg == ST_LINK_KEEP)
            begin
                merge_reg <= merge_reg + 1'b1;
                if (sum_size > largest_reg)
                    largest_reg <= sum_size;
            end
        end
    end

    // Walk datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                node_a_reg <= IW'(edges.node_a);
                node_b_reg <= IW'(edges.node_b);
                walk_reg   <= IW'(edges.node_a);
                side_reg   <= 1'b0;
                bad_reg    <= in_bad;
            end
            ST_FIND_CHK:
            begin
                if (rd_root)
                begin
                    // Root found: restart at the endpoint to compress
                    if (side_reg)
                    begin
                        root_b_reg <= walk_reg;
                        size_b_reg <= rd_size;
                        walk_reg   <= node_b_reg;
                    end
                    else
                    begin
                        root_a_reg <= walk_reg;
                        size_a_reg <= rd_size;
                        walk_reg   <= node_a_reg;
                    end
                end
                else
                    walk_reg <= rd_parent;
            end
            ST_PATH_RD:
            begin
                if (walk_reg == root_cur && !side_reg)
                begin
                    side_reg <= 1'b1;
                    walk_reg <= node_b_reg;
                end
            end
            ST_PATH_CHK:
                walk_reg <= rd_parent;
            default:
                walk_reg <= walk_reg;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (stats.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg   <= COUNT_W'(count_diff);
            out_largest_reg <= COUNT_W'(largest_reg);
            out_bad_reg     <= bad_reg;
        end
    end

    assign stats.valid         = out_valid_reg;
    assign stats.cluster_count = out_count_reg;
    assign stats.largest_size  = out_largest_reg;
    assign stats.bad_node      = out_bad_reg;

endmodule

`default_nettype wire

@@ bench/union_find_cluster_tracker_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// union_find_cluster_tracker_tb: self-checking bench for the cluster tracker
// Drives edge items and node_count writes, keeps its own disjoint-set forest
// (union by size, path compression) to predict each statistics item, and
// compares every returned item field by field. Both channels idle at random;
// the stats side holds off once for a long stretch to back the block up.
// ---------------------------------------------------------------------------
module union_find_cluster_tracker_tb;
    import ufct_pkg::*;

    localparam int TB_NODES = MAX_NODES_DEF;
    // Watchdog limit, far above the reset RAM clearing pass, the walk of a long
    // edge and the long stats hold-off (LONG_HOLD)
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 200;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } edge_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cluster_count;
        logic [COUNT_W-1:0] largest_size;
        logic               bad_node;
    } stats_t;

    logic clk;
    logic rst_n;

    ufct_cfg_if   cfg_ch ();
    ufct_edge_if  edge_ch ();
    ufct_stats_if stats_ch ();

    union_find_cluster_tracker #(
        .MAX_NODES (TB_NODES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .edges (edge_ch),
        .stats (stats_ch)
    );

    // Stimulus and expectation stores
    edge_item_t pending_edges[$];
    stats_t     expected_stats[$];
    edge_item_t next_edge;

    // Predicted forest: size for a root, parent index otherwise
    logic [11:0]        link_or_size [TB_NODES];
    logic               is_root      [TB_NODES];
    logic [NODE_W-1:0]  merge_count;
    logic [COUNT_W-1:0] largest_q;
    logic [COUNT_W-1:0] node_count_q;

    int  mismatch_count;
    int  edges_taken;
    int  stall_cycles;
    int  src_wait;
    int  src_calm;
    int  sink_wait;
    int  sink_calm;
    bit  long_hold_done;
    bit  quiet_tail;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Forest back to singletons, counters back to their reset values
    function automatic void reset_forest();
        for (int i = 0; i < TB_NODES; i++)
        begin
            link_or_size[i] = 12'd1;
            is_root[i]      = 1'b1;
        end
        merge_count = '0;
        largest_q   = COUNT_W'(1);
    endfunction

    // Root search, then point every node on the path straight at the root
    function automatic logic [NODE_W-1:0] find_root_compress(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        int                hops;
        r    = v;
        hops = 0;
        while (!is_root[r] && hops < TB_NODES)
        begin
            r = link_or_size[r][NODE_W-1:0];
            hops++;
        end
        cur  = v;
        hops = 0;
        while (cur != r && !is_root[cur] && hops < TB_NODES)
        begin
            nxt               = link_or_size[cur][NODE_W-1:0];
            link_or_size[cur] = {2'b00, r};
            cur               = nxt;
            hops++;
        end
        return r;
    endfunction

    // Expected statistics for one edge; updates the predicted forest
    function automatic stats_t predict_edge(input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b);
        logic [COUNT_W-1:0] active;
        logic [NODE_W-1:0]  ra;
        logic [NODE_W-1:0]  rb;
        logic [NODE_W-1:0]  keep;
        logic [NODE_W-1:0]  join_root;
        stats_t             res;
        active = (node_count_q > COUNT_W'(TB_NODES)) ? COUNT_W'(TB_NODES) : node_count_q;
        res.bad_node = ({1'b0, a} >= active) || ({1'b0, b} >= active);
        if (!res.bad_node)
        begin
            ra = find_root_compress(a);
            rb = find_root_compress(b);
            if (ra != rb)
            begin
                // smaller set goes under the larger; tie keeps node_a's root
                keep      = ra;
                join_root = rb;
                if (link_or_size[ra] < link_or_size[rb])
                begin
                    keep      = rb;
                    join_root = ra;
                end
                link_or_size[keep]      = link_or_size[keep] + link_or_size[join_root];
                link_or_size[join_root] = {2'b00, keep};
                is_root[join_root]      = 1'b0;
                merge_count++;
                if (link_or_size[keep] > {1'b0, largest_q})
                    largest_q = link_or_size[keep][COUNT_W-1:0];
            end
        end
        res.cluster_count = active - COUNT_W'(merge_count);
        res.largest_size  = largest_q;
        return res;
    endfunction

    task automatic add_edge(input int a, input int b);
        edge_item_t item;
        item.node_a = NODE_W'(a);
        item.node_b = NODE_W'(b);
        pending_edges.push_back(item);
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_idle();
        @(negedge clk);
        while (pending_edges.size() != 0 || edge_ch.valid || expected_stats.size() != 0)
            @(negedge clk);
    endtask

    // Register write; the block reinitializes its forest on it
    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.node_count <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        node_count_q = value;
        reset_forest();
    endtask

    // Random edges: mostly in range, some merge-doubling runs, some noise
    task automatic fill_random(input logic [COUNT_W-1:0] value, input int n_items);
        int active;
        int pushed;
        int pick;
        int kmax;
        int m;
        int base;
        active = (value > COUNT_W'(TB_NODES)) ? TB_NODES : int'(value);
        pushed = 0;
        while (pushed < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (active == 0 || pick < 12 || (active == 1 && pick < 50))
            begin
                add_edge($urandom_range(0, TB_NODES - 1), $urandom_range(0, TB_NODES - 1));
                pushed++;
            end
            else if (active == 1)
            begin
                add_edge(0, 0);
                pushed++;
            end
            else if (pick < 27)
            begin
                // pair equal-size trees to build depth, then search the deepest leaf
                kmax = 1;
                while ((2 << kmax) <= active && kmax < 5)
                    kmax++;
                m    = 1 << $urandom_range(1, kmax);
                base = $urandom_range(0, active - m);
                for (int s = 1; s < m; s = s * 2)
                    for (int i = 0; i + s < m; i = i + 2 * s)
                        add_edge(base + i, base + i + s);
                add_edge(base + m - 1, base);
                pushed += m;
            end
            else
            begin
                add_edge($urandom_range(0, active - 1), $urandom_range(0, active - 1));
                pushed++;
            end
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] value, input int n_items);
        wait_idle();
        write_node_count(value);
        fill_random(value, n_items);
    endtask

    // Compare one returned item with the oldest expectation
    task automatic check_stats();
        stats_t want;
        if (expected_stats.size() == 0)
        begin
            $error("unexpected stats item: cluster_count=%0d largest_size=%0d bad_node=%0d",
                   stats_ch.cluster_count, stats_ch.largest_size, stats_ch.bad_node);
            mismatch_count++;
        end
        else
        begin
            want = expected_stats.pop_front();
            if (stats_ch.cluster_count !== want.cluster_count)
            begin
                $error("cluster_count mismatch: expected %0d, actual %0d",
                       want.cluster_count, stats_ch.cluster_count);
                mismatch_count++;
            end
            if (stats_ch.largest_size !== want.largest_size)
            begin
                $error("largest_size mismatch: expected %0d, actual %0d",
                       want.largest_size, stats_ch.largest_size);
                mismatch_count++;
            end
            if (stats_ch.bad_node !== want.bad_node)
            begin
                $error("bad_node mismatch: expected %0d, actual %0d",
                       want.bad_node, stats_ch.bad_node);
                mismatch_count++;
            end
        end
    endtask

    // Edge driver: predicts on acceptance, then offers the next item or a gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            edge_ch.valid <= 1'b0;
        end
        else
        begin
            if (edge_ch.valid && edge_ch.ready)
            begin
                expected_stats.push_back(predict_edge(edge_ch.node_a, edge_ch.node_b));
                edges_taken++;
            end
            if (src_calm > 0)
                src_calm--;
            else if ($urandom_range(0, 49) == 0)
                src_calm = $urandom_range(20, 60);
            if (!edge_ch.valid || edge_ch.ready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    edge_ch.valid <= 1'b0;
                end
                else if (src_calm == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
                begin
                    src_wait = int'($urandom_range(1, 6)) - 1;
                    edge_ch.valid <= 1'b0;
                end
                else if (pending_edges.size() != 0)
                begin
                    next_edge = pending_edges.pop_front();
                    edge_ch.valid  <= 1'b1;
                    edge_ch.node_a <= next_edge.node_a;
                    edge_ch.node_b <= next_edge.node_b;
                end
                else
                begin
                    edge_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Stats monitor: checks accepted items and throttles ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stats_ch.ready <= 1'b0;
        end
        else
        begin
            if (stats_ch.valid && stats_ch.ready)
                check_stats();
            if (sink_calm > 0)
                sink_calm--;
            else if ($urandom_range(0, 49) == 0)
                sink_calm = $urandom_range(20, 60);
            // one long hold-off so the block fills and stalls its input
            if (!long_hold_done && edges_taken >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                sink_wait      = LONG_HOLD;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                stats_ch.ready <= 1'b0;
            end
            else if (sink_calm == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
            begin
                sink_wait = int'($urandom_range(1, 6)) - 1;
                stats_ch.ready <= 1'b0;
            end
            else
            begin
                stats_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any accepted item
    always @(posedge clk)
    begin
        if ((edge_ch.valid && edge_ch.ready) || (stats_ch.valid && stats_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Sequence of phases
    initial
    begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.node_count   = '0;
        edge_ch.valid       = 1'b0;
        edge_ch.node_a      = '0;
        edge_ch.node_b      = '0;
        stats_ch.ready      = 1'b0;
        mismatch_count      = 0;
        edges_taken         = 0;
        stall_cycles        = 0;
        src_wait            = 0;
        src_calm            = 0;
        sink_wait           = 0;
        sink_calm           = 0;
        long_hold_done      = 1'b0;
        quiet_tail          = 1'b0;
        node_count_q        = COUNT_RESET;
        reset_forest();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset count: field extremes, self loops, alternating bit patterns
        add_edge(0, 1023);
        add_edge(1023, 1023);
        add_edge(0, 0);
        add_edge(1023, 0);
        add_edge(682, 341);

        // Eight nodes: out-of-range ends, ties, smaller node_a set, full merge
        wait_idle();
        write_node_count(COUNT_W'(8));
        add_edge(8, 0);
        add_edge(0, 1023);
        add_edge(1023, 8);
        add_edge(3, 3);
        add_edge(0, 1);
        add_edge(2, 3);
        add_edge(3, 1);
        add_edge(4, 1);
        add_edge(5, 6);
        add_edge(7, 5);
        add_edge(6, 4);
        add_edge(1, 7);
        add_edge(7, 0);

        // Zero nodes: everything flagged, cluster count reads zero
        wait_idle();
        write_node_count(COUNT_W'(0));
        add_edge(0, 0);
        add_edge(7, 3);

        // Single node: only the self loop is legal
        wait_idle();
        write_node_count(COUNT_W'(1));
        add_edge(0, 0);
        add_edge(0, 1);
        add_edge(1023, 0);

        // Count above the forest depth saturates
        wait_idle();
        write_node_count(COUNT_W'(2047));
        add_edge(1023, 512);
        add_edge(0, 1023);

        // Random phases over several node counts
        run_phase(COUNT_W'(1024), 150);
        run_phase(COUNT_W'(16), 120);
        run_phase(COUNT_W'(64), 120);
        run_phase(COUNT_W'(2047), 60);
        run_phase(COUNT_W'(3), 40);
        run_phase(COUNT_W'(0), 15);
        run_phase(COUNT_W'(300), 110);
        run_phase(COUNT_W'(128), 120);

        // Last part at full rate on both sides
        wait_idle();
        quiet_tail = 1'b1;
        run_phase(COUNT_W'(1000), 115);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
